@@ rtl/caop_pkg.sv @@
// ----------------------------------------------------------------------------
// caop_pkg
// Shared types and constants for the charger / ACC power-off qualifier.
// ----------------------------------------------------------------------------
package caop_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_SECOND = 2'd1,
    OP_KEY    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_IN   = 2'd1,
    EV_OUT  = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    REG_ON_THRESHOLD  = 2'd0,
    REG_OFF_THRESHOLD = 2'd1,
    REG_ACC_LIMIT     = 2'd2,
    REG_OFF_DELAY     = 2'd3
  } reg_idx_t;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] ON_THRESHOLD_RST  = 8'd15;
  localparam logic [7:0] OFF_THRESHOLD_RST = 8'd1;
  localparam logic [3:0] ACC_LIMIT_RST     = 4'd5;
  localparam logic [3:0] OFF_DELAY_RST     = 4'd10;

  localparam logic [7:0] CNT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] on_threshold;
    logic [7:0] off_threshold;
    logic [3:0] acc_limit;
    logic [3:0] off_delay_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0] charger_event;
    logic       power_off_request;
    logic       charging;
  } result_t;

endpackage

@@ rtl/caop_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// caop_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module caop_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [caop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [caop_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output caop_pkg::cfg_t                  cfg
);
  import caop_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_threshold      <= ON_THRESHOLD_RST;
      cfg_r.off_threshold     <= OFF_THRESHOLD_RST;
      cfg_r.acc_limit         <= ACC_LIMIT_RST;
      cfg_r.off_delay_seconds <= OFF_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ON_THRESHOLD:  cfg_r.on_threshold      <= cfg_wdata;
        REG_OFF_THRESHOLD: cfg_r.off_threshold     <= cfg_wdata;
        REG_ACC_LIMIT:     cfg_r.acc_limit         <= cfg_wdata[3:0];
        REG_OFF_DELAY:     cfg_r.off_delay_seconds <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/caop_core.sv @@
// ----------------------------------------------------------------------------
// caop_core
// Qualifier state and its single-pass update for one item.
// ----------------------------------------------------------------------------
module caop_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        op,
  input  logic              acc_line,
  input  logic              usb_charging,
  input  caop_pkg::cfg_t    cfg,
  output caop_pkg::result_t res
);
  import caop_pkg::*;

  logic [4:0] acc_count_r, acc_count_nxt;
  logic       acc_on_r, acc_on_nxt;
  logic       acc_prev_r, acc_prev_nxt;
  logic       charge_on_r, charge_on_nxt;
  logic       reported_on_r, reported_on_nxt;
  logic [7:0] plug_count_r, plug_count_nxt;
  logic [7:0] unplug_count_r, unplug_count_nxt;
  logic       armed_r, armed_nxt;
  logic [3:0] seconds_r, seconds_nxt;

  logic [4:0] acc_inc;
  logic [4:0] sec_inc;
  logic [7:0] plug_inc;
  logic [7:0] unplug_inc;

  always_comb begin
    acc_count_nxt    = acc_count_r;
    acc_on_nxt       = acc_on_r;
    acc_prev_nxt     = acc_prev_r;
    charge_on_nxt    = charge_on_r;
    reported_on_nxt  = reported_on_r;
    plug_count_nxt   = plug_count_r;
    unplug_count_nxt = unplug_count_r;
    armed_nxt        = armed_r;
    seconds_nxt      = seconds_r;
    res.charger_event     = EV_NONE;
    res.power_off_request = 1'b0;

    acc_inc    = acc_count_r + 5'd1;
    sec_inc    = {1'b0, seconds_r} + 5'd1;
    plug_inc   = (plug_count_r == CNT_MAX) ? plug_count_r : plug_count_r + 8'd1;
    unplug_inc = (unplug_count_r == CNT_MAX) ? unplug_count_r : unplug_count_r + 8'd1;

    case (op)
      OP_SAMPLE: begin
        // acc debounce, up/down counter clamped at the ceiling
        if (acc_line) begin
          if (acc_inc > {1'b0, cfg.acc_limit}) begin
            acc_on_nxt    = 1'b1;
            acc_count_nxt = {1'b0, cfg.acc_limit};
          end else begin
            acc_count_nxt = acc_inc;
          end
        end else if (acc_count_r != 5'd0) begin
          acc_count_nxt = acc_count_r - 5'd1;
        end else begin
          acc_on_nxt = 1'b0;
        end
        if (acc_prev_r && !acc_on_nxt) begin
          armed_nxt = 1'b1;
        end
        acc_prev_nxt = acc_on_nxt;

        // charger hysteresis
        if (usb_charging) begin
          if (!charge_on_r) begin
            plug_count_nxt = plug_inc;
            if (plug_inc > cfg.on_threshold) begin
              charge_on_nxt = 1'b1;
            end
          end else begin
            unplug_count_nxt = 8'd0;
          end
        end else begin
          if (charge_on_r) begin
            unplug_count_nxt = unplug_inc;
            if (unplug_inc > cfg.off_threshold) begin
              charge_on_nxt = 1'b0;
            end
          end else begin
            plug_count_nxt = 8'd0;
          end
        end

        if (charge_on_nxt != reported_on_r) begin
          reported_on_nxt = charge_on_nxt;
          armed_nxt       = !charge_on_nxt;
          res.charger_event = charge_on_nxt ? EV_IN : EV_OUT;
        end
      end
      OP_SECOND: begin
        if (armed_r) begin
          if (sec_inc >= {1'b0, cfg.off_delay_seconds}) begin
            seconds_nxt = 4'd0;
            armed_nxt   = 1'b0;
            res.power_off_request = 1'b1;
          end else begin
            seconds_nxt = sec_inc[3:0];
          end
        end else begin
          seconds_nxt = 4'd0;
        end
      end
      OP_KEY: begin
        armed_nxt = 1'b0;
      end
      default: ;
    endcase

    res.charging = charge_on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_count_r    <= '0;
      acc_on_r       <= 1'b0;
      acc_prev_r     <= 1'b0;
      charge_on_r    <= 1'b0;
      reported_on_r  <= 1'b0;
      plug_count_r   <= '0;
      unplug_count_r <= '0;
      armed_r        <= 1'b0;
      seconds_r      <= '0;
    end else if (step) begin
      acc_count_r    <= acc_count_nxt;
      acc_on_r       <= acc_on_nxt;
      acc_prev_r     <= acc_prev_nxt;
      charge_on_r    <= charge_on_nxt;
      reported_on_r  <= reported_on_nxt;
      plug_count_r   <= plug_count_nxt;
      unplug_count_r <= unplug_count_nxt;
      armed_r        <= armed_nxt;
      seconds_r      <= seconds_nxt;
    end
  end

endmodule

@@ rtl/charger_acc_power_off_qualifier.sv @@
// ----------------------------------------------------------------------------
// charger_acc_power_off_qualifier
// Debounced ACC and charger presence detect with a shutdown countdown.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result. An item lands in an input
// register, is evaluated against the qualifier state and moves on into
// the result register, so one item per cycle is sustained while the
// output is not stalled; the result is offered at the output from the
// result register. While a result waits at the output the input
// register still takes one more item; the state update for that item
// happens when it moves on into the result register.
module charger_acc_power_off_qualifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic                            in_acc_line,
  input  logic                            in_usb_charging,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_charger_event,
  output logic                            out_power_off_request,
  output logic                            out_charging,
  input  logic                            cfg_we,
  input  logic [caop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [caop_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import caop_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_r;

  logic       in_valid_r;
  logic [1:0] op_r;
  logic       acc_line_r;
  logic       usb_r;
  logic       out_valid_r;
  logic       advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  caop_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  caop_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .op           (op_r),
    .acc_line     (acc_line_r),
    .usb_charging (usb_r),
    .cfg          (cfg),
    .res          (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_op;
      acc_line_r <= in_acc_line;
      usb_r      <= in_usb_charging;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_charger_event     = res_r.charger_event;
  assign out_power_off_request = res_r.power_off_request;
  assign out_charging          = res_r.charging;

  // an empty input stage always takes a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  // a buffered item never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(res_r))
    else $error("stalled result changed");

  // a plug event reports charging, an unplug event reports not charging
  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.charger_event != EV_IN) || res_r.charging) &&
                    ((res_r.charger_event != EV_OUT) || !res_r.charging))
    else $error("charger event disagrees with charging state");

  // power-off comes only from a second tick, never with a charger event
  a_poweroff_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.power_off_request) |-> (res_r.charger_event == EV_NONE))
    else $error("power-off request together with charger event");

endmodule
